### design/xsr_pkg.sv
package xsr_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned FracW = 53;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ActW  = 3;

  localparam logic [WordW-1:0] SeedReset     = 64'd20260705;
  localparam logic [WordW-1:0] ZeroSeedSubst = 64'h9E3779B97F4A7C15;
  localparam logic [WordW-1:0] ScrambleMult  = 64'h2545F4914F6CDD1D;
  localparam int unsigned      ShiftA        = 12;
  localparam int unsigned      ShiftB        = 25;
  localparam int unsigned      ShiftC        = 27;
  localparam logic [PctW-1:0]  PercentMax    = 7'd100;

  localparam int unsigned WarmupSteps = 4;
  localparam int unsigned MulPhases   = 3;
  localparam int unsigned DivSteps    = WordW;
  localparam int unsigned CntW        = $clog2(DivSteps);

  typedef enum logic [ActW-1:0] {
    ACT_RAW     = 3'd0,
    ACT_BELOW   = 3'd1,
    ACT_ROLL    = 3'd2,
    ACT_CHANCE  = 3'd3,
    ACT_FRAC    = 3'd4,
    ACT_RESTART = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_WARM,
    S_IDLE,
    S_DECODE,
    S_STEP,
    S_MUL,
    S_DIVINIT,
    S_DIV
  } state_t;

  typedef struct packed {
    logic [ActW-1:0]         action;
    logic signed [WordW-1:0] bound;
    logic signed [WordW-1:0] range_low;
    logic signed [WordW-1:0] range_high;
    logic [PctW-1:0]         percent;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0]        raw_word;
    logic signed [WordW-1:0] int_result;
    logic                    hit;
    logic [FracW-1:0]        fraction;
  } out_item_t;

  typedef struct packed {
    logic       load_item;
    logic       load_seed;
    logic       do_step;
    logic       mul_en;
    logic [1:0] mul_phase;
    logic       div_init;
    logic       div_en;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic            skip;
  } status_t;

  function automatic logic [WordW-1:0] xs_step(input logic [WordW-1:0] s);
    logic [WordW-1:0] x;
    x = s;
    x = x ^ (x >> ShiftA);
    x = x ^ (x << ShiftB);
    x = x ^ (x >> ShiftC);
    return x;
  endfunction

endpackage

### design/xsr_ctrl.sv
module xsr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  xsr_pkg::status_t status,
  output xsr_pkg::cmd_t    cmd
);

  localparam logic [xsr_pkg::CntW-1:0] WarmLast =
    xsr_pkg::CntW'(xsr_pkg::WarmupSteps - 1);
  localparam logic [xsr_pkg::CntW-1:0] MulLast =
    xsr_pkg::CntW'(xsr_pkg::MulPhases - 1);
  localparam logic [xsr_pkg::CntW-1:0] DivLast =
    xsr_pkg::CntW'(xsr_pkg::DivSteps - 1);

  xsr_pkg::state_t state, state_next;
  logic [xsr_pkg::CntW-1:0] cnt, cnt_next;
  logic done, done_next;
  logic slot_free;
  logic needs_div;

  assign slot_free = !out_valid || out_ready;
  assign needs_div = (status.action == xsr_pkg::ACT_BELOW) ||
                     (status.action == xsr_pkg::ACT_ROLL) ||
                     (status.action == xsr_pkg::ACT_CHANCE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= xsr_pkg::S_LOAD;
      cnt       <= '0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    done_next     = done;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_phase = cnt[1:0];
    // a finished result waits here until the output slot frees up
    if (done && slot_free) begin
      cmd.out_load = 1'b1;
      done_next    = 1'b0;
    end
    unique case (state)
      xsr_pkg::S_LOAD: begin
        cmd.load_seed = 1'b1;
        cnt_next      = '0;
        state_next    = xsr_pkg::S_WARM;
      end
      xsr_pkg::S_WARM: begin
        cmd.do_step = 1'b1;
        cnt_next    = cnt + 1'b1;
        if (cnt == WarmLast) begin
          state_next = xsr_pkg::S_IDLE;
        end
      end
      xsr_pkg::S_IDLE: begin
        in_ready = !done;
        if (in_valid && !done) begin
          cmd.load_item = 1'b1;
          state_next    = xsr_pkg::S_DECODE;
        end
      end
      xsr_pkg::S_DECODE: begin
        cnt_next = '0;
        priority case (status.action)
          xsr_pkg::ACT_RAW, xsr_pkg::ACT_FRAC, xsr_pkg::ACT_CHANCE: begin
            state_next = xsr_pkg::S_STEP;
          end
          xsr_pkg::ACT_BELOW, xsr_pkg::ACT_ROLL: begin
            if (status.skip) begin
              done_next  = 1'b1;
              state_next = xsr_pkg::S_IDLE;
            end else begin
              state_next = xsr_pkg::S_STEP;
            end
          end
          xsr_pkg::ACT_RESTART: begin
            state_next = xsr_pkg::S_LOAD;
          end
          default: begin
            state_next = xsr_pkg::S_IDLE;
          end
        endcase
      end
      xsr_pkg::S_STEP: begin
        cmd.do_step = 1'b1;
        cnt_next    = '0;
        state_next  = xsr_pkg::S_MUL;
      end
      xsr_pkg::S_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == MulLast) begin
          if (needs_div) begin
            state_next = xsr_pkg::S_DIVINIT;
          end else begin
            done_next  = 1'b1;
            state_next = xsr_pkg::S_IDLE;
          end
        end
      end
      xsr_pkg::S_DIVINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = xsr_pkg::S_DIV;
      end
      xsr_pkg::S_DIV: begin
        cmd.div_en = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == DivLast) begin
          done_next  = 1'b1;
          state_next = xsr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = xsr_pkg::S_LOAD;
      end
    endcase
  end

endmodule

### design/xsr_dpath.sv
module xsr_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic signed [xsr_pkg::WordW-1:0] cfg_data,
  input  xsr_pkg::in_item_t               in_data,
  input  xsr_pkg::cmd_t                   cmd,
  output xsr_pkg::status_t                status,
  output xsr_pkg::out_item_t              out_data
);

  localparam int unsigned HalfW = xsr_pkg::WordW / 2;

  logic [xsr_pkg::WordW-1:0] seed;
  logic [xsr_pkg::WordW-1:0] gen_state;
  logic [xsr_pkg::WordW-1:0] acc;
  logic [xsr_pkg::WordW-1:0] rem;
  logic [xsr_pkg::WordW-1:0] dvd;
  logic [xsr_pkg::WordW-1:0] divisor;
  logic [xsr_pkg::WordW-1:0] range_low;
  logic [xsr_pkg::PctW-1:0]  pct;
  logic [xsr_pkg::ActW-1:0]  action;
  logic                      skip;

  logic [xsr_pkg::WordW-1:0] span;
  logic                      roll_skip;
  logic [HalfW-1:0]          mul_a, mul_b;
  logic [xsr_pkg::WordW-1:0] prod;
  logic [xsr_pkg::WordW-1:0] rem_sh;
  xsr_pkg::out_item_t        out_data_next;

  assign status.action = action;
  assign status.skip   = skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= xsr_pkg::SeedReset;
    end else if (cfg_valid) begin
      seed <= cfg_data;
    end
  end

  assign span      = in_data.range_high - in_data.range_low + 1'b1;
  assign roll_skip = ($signed(in_data.range_high) <= $signed(in_data.range_low)) ||
                     (span == '0) || span[xsr_pkg::WordW-1];

  // capture the item and pick the modulus it needs
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      action    <= in_data.action;
      range_low <= in_data.range_low;
      pct       <= (in_data.percent > xsr_pkg::PercentMax) ?
                   xsr_pkg::PercentMax : in_data.percent;
      priority case (in_data.action)
        xsr_pkg::ACT_BELOW: begin
          divisor <= in_data.bound;
          skip    <= ($signed(in_data.bound) <= $signed(xsr_pkg::WordW'(0)));
        end
        xsr_pkg::ACT_ROLL: begin
          divisor <= span;
          skip    <= roll_skip;
        end
        default: begin
          divisor <= xsr_pkg::WordW'(xsr_pkg::PercentMax);
          skip    <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      gen_state <= (seed != '0) ? seed : xsr_pkg::ZeroSeedSubst;
    end else if (cmd.do_step) begin
      gen_state <= xsr_pkg::xs_step(gen_state);
    end
  end

  // low word of state * constant from three 32x32 partial products
  always_comb begin
    unique case (cmd.mul_phase)
      2'd0: begin
        mul_a = gen_state[HalfW-1:0];
        mul_b = xsr_pkg::ScrambleMult[HalfW-1:0];
      end
      2'd1: begin
        mul_a = gen_state[xsr_pkg::WordW-1:HalfW];
        mul_b = xsr_pkg::ScrambleMult[HalfW-1:0];
      end
      default: begin
        mul_a = gen_state[HalfW-1:0];
        mul_b = xsr_pkg::ScrambleMult[xsr_pkg::WordW-1:HalfW];
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      if (cmd.mul_phase == 2'd0) begin
        acc <= prod;
      end else begin
        acc <= acc + {prod[HalfW-1:0], {HalfW{1'b0}}};
      end
    end
  end

  // restoring remainder, one dividend bit per cycle
  assign rem_sh = {rem[xsr_pkg::WordW-2:0], dvd[xsr_pkg::WordW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= '0;
      dvd <= acc;
    end else if (cmd.div_en) begin
      dvd <= {dvd[xsr_pkg::WordW-2:0], 1'b0};
      rem <= (rem_sh >= divisor) ? (rem_sh - divisor) : rem_sh;
    end
  end

  always_comb begin
    out_data_next = '0;
    priority case (action)
      xsr_pkg::ACT_RAW: begin
        out_data_next.raw_word = acc;
      end
      xsr_pkg::ACT_BELOW: begin
        out_data_next.int_result = skip ? '0 : rem;
      end
      xsr_pkg::ACT_ROLL: begin
        out_data_next.int_result = range_low + (skip ? '0 : rem);
      end
      xsr_pkg::ACT_CHANCE: begin
        out_data_next.hit = (rem < xsr_pkg::WordW'(pct));
      end
      xsr_pkg::ACT_FRAC: begin
        out_data_next.fraction =
          acc[xsr_pkg::WordW-1:xsr_pkg::WordW-xsr_pkg::FracW];
      end
      default: begin
        out_data_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= out_data_next;
    end
  end

endmodule

### design/xorshift64_star_range_generator.sv
// xorshift64* generator with range helpers. Send one item per request on
// in_valid/in_ready; each item except restart and the unused action codes
// returns one result item on out_valid/out_ready, and unused fields read 0.
// Raw and fraction draws step the state, then form three 32x32 partial
// products through one shared multiplier before the next item is taken.
// Below-bound, roll and chance draws then run the modulo through a
// radix-2 restoring remainder unit, one dividend bit per cycle over all
// 64 dividend bits. A below-bound or roll item that needs no draw returns
// without stepping the state; restart reloads the seed and runs four
// warm-up steps. After reset the block loads the reset seed and warms up
// before in_ready rises. The seed register is written through
// cfg_valid/cfg_ready, which is always ready; write it while idle.
module xorshift64_star_range_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  xsr_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output xsr_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic signed [xsr_pkg::WordW-1:0] cfg_data
);

  xsr_pkg::cmd_t    cmd;
  xsr_pkg::status_t status;

  // seed writes go straight into a register, so never hold the config channel
  assign cfg_ready = 1'b1;

  xsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  xsr_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // only one datapath unit advances at a time
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_seed, cmd.do_step, cmd.mul_en, cmd.div_init, cmd.div_en}))
    else $error("more than one datapath unit commanded");

  // drop in_ready for the item just taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted item");

  // every seed reload is followed by warm-up steps
  a_warm_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_seed |=> cmd.do_step)
    else $error("seed load not followed by a warm-up step");

  // a result is written only into a free output slot
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");
`endif

endmodule

### tb/tb_xorshift64_star_range_generator.sv
`timescale 1ns / 1ps

module tb_xorshift64_star_range_generator;

  // Action codes 6 and 7 are not decoded by the block; it drops such items.
  localparam logic [xsr_pkg::ActW-1:0] ActSpareA = 3'd6;
  localparam logic [xsr_pkg::ActW-1:0] ActSpareB = 3'd7;

  localparam logic [xsr_pkg::WordW-1:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [xsr_pkg::WordW-1:0] MinNeg = 64'h8000_0000_0000_0000;
  localparam logic [xsr_pkg::WordW-1:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  // Items to draw across all random phases (ignored codes not counted).
  localparam int unsigned DrawTarget = 850;
  // Longest own work of the block is a modulo draw.
  localparam int unsigned SettleCycles = 100;

  // Tracks the generator state and the seed register, works out the
  // result of each accepted request and holds those results in order.
  class draw_checker;
    logic [xsr_pkg::WordW-1:0] seed_reg;
    logic [xsr_pkg::WordW-1:0] gen;
    xsr_pkg::out_item_t        expected_draws[$];
    int unsigned               mismatches;

    function new();
      seed_reg    = xsr_pkg::SeedReset;
      mismatches  = 0;
      reload();
    endfunction

    // One generator step; return the scrambled word.
    function logic [xsr_pkg::WordW-1:0] next_word();
      logic [xsr_pkg::WordW-1:0] x;
      x = gen;
      x ^= x >> xsr_pkg::ShiftA;
      x ^= x << xsr_pkg::ShiftB;
      x ^= x >> xsr_pkg::ShiftC;
      gen = x;
      return x * xsr_pkg::ScrambleMult;
    endfunction

    // Load from the seed (zero swapped for the fixed constant), then warm up.
    function void reload();
      int i;
      gen = (seed_reg != '0) ? seed_reg : xsr_pkg::ZeroSeedSubst;
      for (i = 0; i < xsr_pkg::WarmupSteps; i++) begin
        void'(next_word());
      end
    endfunction

    // A nonpositive limit draws nothing and leaves the state alone.
    function logic [xsr_pkg::WordW-1:0] draw_below(logic [xsr_pkg::WordW-1:0] n);
      if (n == '0 || n[xsr_pkg::WordW-1]) begin
        return '0;
      end
      return next_word() % n;
    endfunction

    function void note_request(xsr_pkg::in_item_t it);
      xsr_pkg::out_item_t        want;
      logic [xsr_pkg::WordW-1:0] span;
      logic [xsr_pkg::PctW-1:0]  pct;
      logic [xsr_pkg::WordW-1:0] word;
      want = '0;
      case (it.action)
        xsr_pkg::ACT_RAW: begin
          want.raw_word = next_word();
        end
        xsr_pkg::ACT_BELOW: begin
          want.int_result = draw_below(it.bound);
        end
        xsr_pkg::ACT_ROLL: begin
          if ($signed(it.range_high) <= $signed(it.range_low)) begin
            want.int_result = it.range_low;
          end else begin
            span = it.range_high - it.range_low + 64'd1;
            want.int_result = it.range_low + draw_below(span);
          end
        end
        xsr_pkg::ACT_CHANCE: begin
          pct = (it.percent > xsr_pkg::PercentMax) ? xsr_pkg::PercentMax : it.percent;
          want.hit = (draw_below(64'(xsr_pkg::PercentMax)) < 64'(pct));
        end
        xsr_pkg::ACT_FRAC: begin
          word = next_word();
          want.fraction = word[xsr_pkg::WordW-1:xsr_pkg::WordW-xsr_pkg::FracW];
        end
        xsr_pkg::ACT_RESTART: begin
          reload();
          return;
        end
        default: begin
          return;
        end
      endcase
      expected_draws.push_back(want);
    endfunction

    task report_mismatch(string what, logic [xsr_pkg::WordW-1:0] got,
                         logic [xsr_pkg::WordW-1:0] want);
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(xsr_pkg::out_item_t got);
      xsr_pkg::out_item_t want;
      if (expected_draws.size() == 0) begin
        report_mismatch("unexpected result", got.raw_word, '0);
        return;
      end
      want = expected_draws.pop_front();
      if (got.raw_word !== want.raw_word) begin
        report_mismatch("raw_word", got.raw_word, want.raw_word);
      end
      if (got.int_result !== want.int_result) begin
        report_mismatch("int_result", got.int_result, want.int_result);
      end
      if (got.hit !== want.hit) begin
        report_mismatch("hit", 64'(got.hit), 64'(want.hit));
      end
      if (got.fraction !== want.fraction) begin
        report_mismatch("fraction", 64'(got.fraction), 64'(want.fraction));
      end
    endtask

    function int unsigned pending();
      return expected_draws.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  xsr_pkg::in_item_t                in_data;
  logic                             out_valid;
  logic                             out_ready;
  xsr_pkg::out_item_t               out_data;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic signed [xsr_pkg::WordW-1:0] cfg_data;

  draw_checker  sb;
  int unsigned  burst_left;
  int unsigned  stall_mode;
  int unsigned  stall_left;
  int unsigned  stall_tick;

  xorshift64_star_range_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [xsr_pkg::WordW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic xsr_pkg::in_item_t make_item(logic [xsr_pkg::ActW-1:0] act,
                                                  logic [xsr_pkg::WordW-1:0] bnd,
                                                  logic [xsr_pkg::WordW-1:0] lo,
                                                  logic [xsr_pkg::WordW-1:0] hi,
                                                  logic [xsr_pkg::PctW-1:0] pct);
    xsr_pkg::in_item_t it;
    it.action     = act;
    it.bound      = bnd;
    it.range_low  = lo;
    it.range_high = hi;
    it.percent    = pct;
    return it;
  endfunction

  // Small bounds dominate so remainders stay interesting; the rest covers
  // full-width words, powers of two, the top of the positive range and
  // nonpositive bounds.
  function automatic logic [xsr_pkg::WordW-1:0] rand_bound();
    logic [xsr_pkg::WordW-1:0] w;
    w = rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 64'($urandom_range(1, 1000));
      4, 5:       return w;
      6:          return 64'd1 << $urandom_range(0, 62);
      7: begin
        w[xsr_pkg::WordW-1] = 1'b0;
        return w;
      end
      8:          return ($urandom_range(0, 1) != 0) ? '0 : (w | MinNeg);
      default:    return MaxPos - 64'($urandom_range(0, 3));
    endcase
  endfunction

  // Mostly small forward spans; also empty or reversed ranges, random
  // endpoints, and spans so wide that they wrap or go negative.
  function automatic void pick_range(output logic [xsr_pkg::WordW-1:0] lo,
                                     output logic [xsr_pkg::WordW-1:0] hi);
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        lo = 64'($urandom_range(0, 2000)) - 64'd1000;
        hi = lo + 64'($urandom_range(0, 200));
      end
      3: begin
        lo = rand_word();
        hi = lo + 64'($urandom_range(1, 1 << 20));
      end
      4: begin
        lo = rand_word();
        hi = rand_word();
      end
      5: begin
        lo = 64'($urandom_range(0, 2000)) - 64'd1000;
        hi = lo - 64'($urandom_range(0, 50));
      end
      6: begin
        lo = MinNeg + 64'($urandom_range(0, 3));
        hi = MaxPos - 64'($urandom_range(0, 3));
      end
      default: begin
        lo = 64'd0 - 64'($urandom_range(0, 1000));
        hi = MaxPos - 64'($urandom_range(0, 1000));
      end
    endcase
  endfunction

  // Every field gets random bits; only the ones the action uses are shaped.
  function automatic xsr_pkg::in_item_t rand_request();
    xsr_pkg::in_item_t         it;
    int unsigned               sel;
    logic [xsr_pkg::WordW-1:0] lo;
    logic [xsr_pkg::WordW-1:0] hi;
    it  = make_item(xsr_pkg::ACT_RAW, rand_word(), rand_word(), rand_word(),
                    xsr_pkg::PctW'($urandom));
    sel = $urandom_range(0, 99);
    if (sel < 14) begin
      it.action = xsr_pkg::ACT_RAW;
    end else if (sel < 34) begin
      it.action = xsr_pkg::ACT_BELOW;
      it.bound  = rand_bound();
    end else if (sel < 58) begin
      it.action = xsr_pkg::ACT_ROLL;
      pick_range(lo, hi);
      it.range_low  = lo;
      it.range_high = hi;
    end else if (sel < 72) begin
      it.action  = xsr_pkg::ACT_CHANCE;
      it.percent = xsr_pkg::PctW'($urandom_range(0, 127));
    end else if (sel < 86) begin
      it.action = xsr_pkg::ACT_FRAC;
    end else if (sel < 94) begin
      it.action = xsr_pkg::ACT_RESTART;
    end else begin
      it.action = ($urandom_range(0, 1) != 0) ? ActSpareA : ActSpareB;
    end
    return it;
  endfunction

  // Present one item and hold it until accepted. Keep valid up within a
  // burst; at the end of a burst drop valid, scramble the payload and idle.
  task automatic send_item(xsr_pkg::in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= make_item(ActSpareA, rand_word(), rand_word(), rand_word(),
                            xsr_pkg::PctW'($urandom));
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Write the seed register; the new seed takes effect at the next restart.
  task automatic write_seed(logic [xsr_pkg::WordW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.seed_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every pending result, then let a trailing
  // restart or draw finish inside the block.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    burst_left = $urandom_range(1, 24);
  endtask

  // Receiver: switch between always-ready, coin-flip, mostly-stalled and
  // periodic patterns, each held for a random stretch.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) != 0);
      2:       out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= stall_tick[3];
    endcase
  end

  // Check each accepted result against the oldest pending expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  initial begin
    xsr_pkg::in_item_t         directed[$];
    logic [xsr_pkg::WordW-1:0] seeds[$];
    xsr_pkg::in_item_t         it;
    int unsigned               per_phase;
    int unsigned               drawn;

    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    stall_mode = 0;
    stall_left = 0;
    stall_tick = 0;
    burst_left = $urandom_range(1, 24);
    sb         = new();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pass on the reset seed: each action, bound and range edges,
    // percent saturation, ignored codes, and a restart mid-stream.
    directed.push_back(make_item(xsr_pkg::ACT_RAW,     '0, '0, '0, '0));
    directed.push_back(make_item(xsr_pkg::ACT_FRAC,    '0, '0, '0, '0));
    directed.push_back(make_item(xsr_pkg::ACT_BELOW,   '0, '0, '0, '0));
    directed.push_back(make_item(xsr_pkg::ACT_BELOW,   AllOnes, '0, '0, '0));
    directed.push_back(make_item(xsr_pkg::ACT_BELOW,   MinNeg, '0, '0, '0));
    directed.push_back(make_item(xsr_pkg::ACT_BELOW,   64'd1, '0, '0, '0));
    directed.push_back(make_item(xsr_pkg::ACT_BELOW,   MaxPos, '0, '0, '0));
    directed.push_back(make_item(xsr_pkg::ACT_BELOW,   64'd10, '0, '0, '0));
    directed.push_back(make_item(xsr_pkg::ACT_ROLL,    '0, 64'd5, 64'd5, '0));
    directed.push_back(make_item(xsr_pkg::ACT_ROLL,    '0, 64'd5, -64'sd5, '0));
    directed.push_back(make_item(xsr_pkg::ACT_ROLL,    '0, -64'sd5, 64'd5, '0));
    // full signed range: span wraps to zero
    directed.push_back(make_item(xsr_pkg::ACT_ROLL,    '0, MinNeg, MaxPos, '0));
    // span of 2^63 reads negative
    directed.push_back(make_item(xsr_pkg::ACT_ROLL,    '0, MinNeg, AllOnes, '0));
    directed.push_back(make_item(xsr_pkg::ACT_ROLL,    '0, 64'd1, MaxPos, '0));
    directed.push_back(make_item(xsr_pkg::ACT_ROLL,    '0, MaxPos, MinNeg, '0));
    directed.push_back(make_item(xsr_pkg::ACT_CHANCE,  '0, '0, '0, 7'd0));
    directed.push_back(make_item(xsr_pkg::ACT_CHANCE,  '0, '0, '0, 7'd100));
    directed.push_back(make_item(xsr_pkg::ACT_CHANCE,  '0, '0, '0, 7'd101));
    directed.push_back(make_item(xsr_pkg::ACT_CHANCE,  '0, '0, '0, 7'd127));
    directed.push_back(make_item(xsr_pkg::ACT_CHANCE,  '0, '0, '0, 7'd50));
    directed.push_back(make_item(ActSpareA,            AllOnes, AllOnes, AllOnes, 7'd127));
    directed.push_back(make_item(ActSpareB,            '0, '0, '0, '0));
    directed.push_back(make_item(xsr_pkg::ACT_RESTART, '0, '0, '0, '0));
    directed.push_back(make_item(xsr_pkg::ACT_RAW,     '0, '0, '0, '0));
    directed.push_back(make_item(xsr_pkg::ACT_FRAC,    AllOnes, AllOnes, AllOnes, 7'd127));
    foreach (directed[i]) begin
      send_item(directed[i]);
    end
    drain();

    // Random phases, one per seed: zero (swapped for the constant), the
    // signed extremes, minus one, one, and two random seeds.
    seeds.push_back('0);
    seeds.push_back(MaxPos);
    seeds.push_back(MinNeg);
    seeds.push_back(AllOnes);
    seeds.push_back(64'd1);
    seeds.push_back(rand_word());
    seeds.push_back(rand_word());
    per_phase = DrawTarget / seeds.size();
    foreach (seeds[p]) begin
      write_seed(seeds[p]);
      send_item(make_item(xsr_pkg::ACT_RESTART, rand_word(), rand_word(), rand_word(),
                          xsr_pkg::PctW'($urandom)));
      drawn = 0;
      while (drawn < per_phase) begin
        it = rand_request();
        send_item(it);
        if (it.action <= xsr_pkg::ACT_RESTART) begin
          drawn++;
        end
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
